// ===== design/spb_pkg.sv =====
// ----------------------------------------------------------------------------
// Spherical polygon bounds package
// Shared widths, fixed-point angle constants, pole codes and the structures
// passed between the accumulator, the bounds stage and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package spb_pkg;

  localparam int FracBits = 16;
  localparam int LonW     = 26;
  localparam int LonXW    = LonW + 1;
  localparam int LatW     = 24;
  localparam int StepW    = 37;
  localparam int LatSumW  = 36;
  localparam int TolW     = 16;
  localparam int PoleW    = 2;
  localparam int InDataW  = 56;
  localparam int OutDataW = 104;

  localparam logic signed [LonXW-1:0] Deg90  = LonXW'(90 * (1 << FracBits));
  localparam logic signed [LonXW-1:0] Deg180 = LonXW'(180 * (1 << FracBits));
  localparam logic signed [LonXW-1:0] Deg270 = LonXW'(270 * (1 << FracBits));
  localparam logic signed [LonXW-1:0] Deg360 = LonXW'(360 * (1 << FracBits));
  localparam logic signed [LonXW-1:0] Deg450 = LonXW'(450 * (1 << FracBits));
  localparam logic signed [LonXW-1:0] Deg720 = LonXW'(720 * (1 << FracBits));

  localparam logic signed [LonW-1:0] Lon360 = LonW'(360 * (1 << FracBits));
  localparam logic signed [LatW-1:0] Lat90  = LatW'(90 * (1 << FracBits));

  typedef enum logic [PoleW-1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

  typedef struct packed {
    logic signed [LonW-1:0]    min_0360;
    logic signed [LonW-1:0]    max_0360;
    logic signed [LonW-1:0]    min_pm;
    logic signed [LonW-1:0]    max_pm;
    logic [3:0]                quads;
    logic signed [StepW-1:0]   step_sum;
    logic signed [LatSumW-1:0] lat_total;
    logic signed [LatW-1:0]    lat_min;
    logic signed [LatW-1:0]    lat_max;
  } acc_snap_t;

  typedef struct packed {
    logic signed [LonW-1:0] lon_low;
    logic signed [LonW-1:0] lon_high;
    logic signed [LatW-1:0] lat_low;
    logic signed [LatW-1:0] lat_high;
    pole_e                  pole_code;
  } bounds_t;

endpackage

`default_nettype wire

// ===== design/spb_accum.sv =====
// ----------------------------------------------------------------------------
// Spherical polygon bounds accumulator
// Registers each vertex, folds its longitude into both notations, tracks the
// ranges, quadrants and saturating sums, and hands a snapshot on the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module spb_accum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [spb_pkg::LonW-1:0]     in_lon_i,
  input  logic signed [spb_pkg::LatW-1:0]     in_lat_i,
  input  logic                                in_last_i,
  output logic                                snap_valid_o,
  input  logic                                snap_ready_i,
  output spb_pkg::acc_snap_t                  snap_o
);

  logic                                  in_valid_q, in_valid_d;
  logic signed [spb_pkg::LonW-1:0]       in_lon_q;
  logic signed [spb_pkg::LatW-1:0]       in_lat_q;
  logic                                  in_last_q;
  logic                                  load;
  logic                                  take;

  logic                                  first_q, first_d;
  logic signed [spb_pkg::LonW-1:0]       prev_lon_q, prev_lon_d;
  spb_pkg::acc_snap_t                    acc_q, acc_d, acc_upd, acc_reset;
  logic                                  snap_valid_q, snap_valid_d;
  spb_pkg::acc_snap_t                    snap_q;

  logic signed [spb_pkg::LonXW-1:0]      lon_x, prev_x, fold1, fold2, pos_x, pm_x;
  logic [2:0]                            qidx;
  logic signed [spb_pkg::LonXW-1:0]      d, abs_d, wrap_diff, mag, step_d;
  logic signed [spb_pkg::StepW:0]        step_wide;
  logic signed [spb_pkg::StepW-1:0]      step_new;
  logic signed [spb_pkg::LatSumW:0]      lat_wide;
  logic signed [spb_pkg::LatSumW-1:0]    lat_new;
  logic signed [spb_pkg::LonW-1:0]       pos_v, pm_v;

  assign take       = in_valid_q && (!in_last_q || !snap_valid_q || snap_ready_i);
  assign in_ready_o = !in_valid_q || take;
  assign load       = in_valid_i && in_ready_o;
  assign in_valid_d = load ? 1'b1 : (take ? 1'b0 : in_valid_q);

  always_comb begin
    acc_reset           = '0;
    acc_reset.min_0360  = spb_pkg::Lon360;
    acc_reset.max_0360  = -spb_pkg::Lon360;
    acc_reset.min_pm    = spb_pkg::Lon360;
    acc_reset.max_pm    = -spb_pkg::Lon360;
  end

  always_comb begin
    lon_x  = spb_pkg::LonXW'(in_lon_q);
    prev_x = spb_pkg::LonXW'(prev_lon_q);
    fold1  = lon_x + spb_pkg::Deg360;
    fold2  = lon_x + spb_pkg::Deg720;
    if (in_lon_q[spb_pkg::LonW-1]) begin
      pos_x = fold1[spb_pkg::LonXW-1] ? fold2 : fold1;
    end else begin
      pos_x = lon_x;
    end
    qidx = 3'(pos_x >= spb_pkg::Deg90) + 3'(pos_x >= spb_pkg::Deg180)
         + 3'(pos_x >= spb_pkg::Deg270) + 3'(pos_x >= spb_pkg::Deg360)
         + 3'(pos_x >= spb_pkg::Deg450);
    pm_x  = (pos_x > spb_pkg::Deg180) ? pos_x - spb_pkg::Deg360 : pos_x;
    pos_v = pos_x[spb_pkg::LonW-1:0];
    pm_v  = pm_x[spb_pkg::LonW-1:0];

    d         = lon_x - prev_x;
    abs_d     = d[spb_pkg::LonXW-1] ? -d : d;
    wrap_diff = spb_pkg::Deg360 - abs_d;
    mag       = wrap_diff[spb_pkg::LonXW-1] ? -wrap_diff : wrap_diff;
    if (abs_d > spb_pkg::Deg180) begin
      step_d = (d > 0) ? -mag : mag;
    end else begin
      step_d = d;
    end

    step_wide = (spb_pkg::StepW+1)'(acc_q.step_sum) + (spb_pkg::StepW+1)'(step_d);
    if (step_wide[spb_pkg::StepW] != step_wide[spb_pkg::StepW-1]) begin
      step_new = step_wide[spb_pkg::StepW] ? {1'b1, {(spb_pkg::StepW-1){1'b0}}}
                                           : {1'b0, {(spb_pkg::StepW-1){1'b1}}};
    end else begin
      step_new = step_wide[spb_pkg::StepW-1:0];
    end

    lat_wide = (spb_pkg::LatSumW+1)'(acc_q.lat_total) + (spb_pkg::LatSumW+1)'(in_lat_q);
    if (lat_wide[spb_pkg::LatSumW] != lat_wide[spb_pkg::LatSumW-1]) begin
      lat_new = lat_wide[spb_pkg::LatSumW] ? {1'b1, {(spb_pkg::LatSumW-1){1'b0}}}
                                           : {1'b0, {(spb_pkg::LatSumW-1){1'b1}}};
    end else begin
      lat_new = lat_wide[spb_pkg::LatSumW-1:0];
    end

    acc_upd = acc_q;
    if (first_q) begin
      acc_upd.lat_min = in_lat_q;
      acc_upd.lat_max = in_lat_q;
    end else begin
      if (pos_v < acc_q.min_0360) acc_upd.min_0360 = pos_v;
      if (pos_v > acc_q.max_0360) acc_upd.max_0360 = pos_v;
      if (pm_v < acc_q.min_pm) acc_upd.min_pm = pm_v;
      if (pm_v > acc_q.max_pm) acc_upd.max_pm = pm_v;
      acc_upd.quads     = acc_q.quads | (4'b0001 << qidx[1:0]);
      acc_upd.step_sum  = step_new;
      acc_upd.lat_total = lat_new;
      if (in_lat_q < acc_q.lat_min) acc_upd.lat_min = in_lat_q;
      if (in_lat_q > acc_q.lat_max) acc_upd.lat_max = in_lat_q;
    end
  end

  always_comb begin
    first_d      = first_q;
    prev_lon_d   = prev_lon_q;
    acc_d        = acc_q;
    snap_valid_d = snap_ready_i ? 1'b0 : snap_valid_q;
    if (take) begin
      if (in_last_q) begin
        first_d      = 1'b1;
        prev_lon_d   = '0;
        acc_d        = acc_reset;
        snap_valid_d = 1'b1;
      end else begin
        first_d    = 1'b0;
        prev_lon_d = in_lon_q;
        acc_d      = acc_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      first_q      <= 1'b1;
      prev_lon_q   <= '0;
      acc_q        <= acc_reset;
      snap_valid_q <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      first_q      <= first_d;
      prev_lon_q   <= prev_lon_d;
      acc_q        <= acc_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_lon_q  <= in_lon_i;
      in_lat_q  <= in_lat_i;
      in_last_q <= in_last_i;
    end
    if (take && in_last_q) begin
      snap_q <= acc_upd;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

`default_nettype wire

// ===== design/spb_bounds.sv =====
// ----------------------------------------------------------------------------
// Spherical polygon bounds result stage
// Tests the step sum for an enclosed pole, picks the longitude notation from
// the quadrants seen and the two spans, normalises the bounds and holds them
// in the result register until the request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module spb_bounds (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [spb_pkg::TolW-1:0]        tolerance_i,
  input  logic                            snap_valid_i,
  output logic                            snap_ready_o,
  input  spb_pkg::acc_snap_t              snap_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output spb_pkg::bounds_t                res_o
);

  logic                                 res_valid_q, res_valid_d;
  spb_pkg::bounds_t                     res_q, res_d;
  logic                                 load;

  logic signed [spb_pkg::StepW:0]       step_x, step_abs;
  logic signed [spb_pkg::StepW+1:0]     dev, dev_abs;
  logic                                 pole;
  logic [2:0]                           nq;
  logic                                 use_pm;
  logic signed [spb_pkg::LonXW-1:0]     span_0360, span_pm;
  logic signed [spb_pkg::LonXW-1:0]     lo_sel, hi_sel, lo_adj, lo_fin, hi_fin;
  logic [3:0]                           q;

  assign snap_ready_o = !res_valid_q || res_ready_i;
  assign load         = snap_valid_i && snap_ready_o;
  assign res_valid_d  = load ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);

  always_comb begin
    q        = snap_i.quads;
    step_x   = (spb_pkg::StepW+1)'(snap_i.step_sum);
    step_abs = step_x[spb_pkg::StepW] ? -step_x : step_x;
    dev      = (spb_pkg::StepW+2)'(step_abs) - (spb_pkg::StepW+2)'(spb_pkg::Deg360);
    dev_abs  = dev[spb_pkg::StepW+1] ? -dev : dev;
    pole     = $unsigned(dev_abs) < (spb_pkg::StepW+2)'(tolerance_i);

    nq        = 3'(q[0]) + 3'(q[1]) + 3'(q[2]) + 3'(q[3]);
    span_0360 = spb_pkg::LonXW'(snap_i.max_0360) - spb_pkg::LonXW'(snap_i.min_0360);
    span_pm   = spb_pkg::LonXW'(snap_i.max_pm) - spb_pkg::LonXW'(snap_i.min_pm);
    if (q[0] && q[3]) begin
      use_pm = 1'b1;
    end else if (q[1] && q[2]) begin
      use_pm = 1'b0;
    end else if (nq == 3'd2 && ((q[0] && q[2]) || (q[1] && q[3]))) begin
      use_pm = !(span_0360 < span_pm);
    end else begin
      use_pm = 1'b0;
    end

    lo_sel = use_pm ? spb_pkg::LonXW'(snap_i.min_pm) : spb_pkg::LonXW'(snap_i.min_0360);
    hi_sel = use_pm ? spb_pkg::LonXW'(snap_i.max_pm) : spb_pkg::LonXW'(snap_i.max_0360);
    lo_adj = (lo_sel > hi_sel) ? lo_sel - spb_pkg::Deg360 : lo_sel;
    if (lo_adj[spb_pkg::LonXW-1] && hi_sel[spb_pkg::LonXW-1]) begin
      lo_fin = lo_adj + spb_pkg::Deg360;
      hi_fin = hi_sel + spb_pkg::Deg360;
    end else begin
      lo_fin = lo_adj;
      hi_fin = hi_sel;
    end

    res_d.lat_low  = snap_i.lat_min;
    res_d.lat_high = snap_i.lat_max;
    if (pole) begin
      res_d.lon_low  = '0;
      res_d.lon_high = spb_pkg::Lon360;
      if (snap_i.lat_total[spb_pkg::LatSumW-1]) begin
        res_d.pole_code = spb_pkg::POLE_SOUTH;
        res_d.lat_low   = -spb_pkg::Lat90;
      end else begin
        res_d.pole_code = spb_pkg::POLE_NORTH;
        res_d.lat_high  = spb_pkg::Lat90;
      end
    end else begin
      res_d.lon_low   = lo_fin[spb_pkg::LonW-1:0];
      res_d.lon_high  = hi_fin[spb_pkg::LonW-1:0];
      res_d.pole_code = spb_pkg::POLE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/spherical_polygon_bounds_top.sv =====
// ----------------------------------------------------------------------------
// Spherical polygon bounds, top level
// Streams the vertices of one closed spherical polygon in, one per request,
// and returns the bounding sector of the polygon after its last vertex.
// The slave channel carries longitude and latitude in tdata and marks the
// final vertex of a polygon with tlast. Every vertex produces nothing except
// the last, which produces one result request on the master channel.
// One vertex is accepted every cycle unless a last vertex waits for the
// snapshot stage; the accumulator update is a single pass of folds, compares
// and one saturating add per sum behind the input register. A result passes
// the input register, the accumulator snapshot and the result register after
// its last vertex is accepted.
// When the receiver stalls, the result waits in the result register while
// vertices of the next polygon keep flowing until a second last vertex
// finds the snapshot stage still occupied.
// Reset restarts every accumulator and sets the pole tolerance to one unit.
// The tolerance is written over the configuration channel, which is always
// ready, and should be changed only while no polygon is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module spherical_polygon_bounds_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spb_pkg::TolW-1:0]         cfg_data_i,   // pole_tolerance
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // vertex_lon [25:0], vertex_lat [49:26], zero [55:50]
  input  logic [spb_pkg::InDataW-1:0]      s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // lon_low [25:0], lon_high [51:26], lat_low [75:52], lat_high [99:76],
  // pole_code [101:100], zero [103:102]
  output logic [spb_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  logic [spb_pkg::TolW-1:0] tol_q;
  logic                     snap_valid;
  logic                     snap_ready;
  spb_pkg::acc_snap_t       snap;
  spb_pkg::bounds_t         result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= spb_pkg::TolW'(1);
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  spb_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_lon_i     (s_axis_tdata_i[spb_pkg::LonW-1:0]),
    .in_lat_i     (s_axis_tdata_i[spb_pkg::LonW+spb_pkg::LatW-1:spb_pkg::LonW]),
    .in_last_i    (s_axis_tlast_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  spb_bounds u_bounds (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tolerance_i  (tol_q),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (result)
  );

  assign m_axis_tdata_o = {2'b00, result.pole_code, result.lat_high, result.lat_low,
                           result.lon_high, result.lon_low};

`ifndef ASSERT_OFF
  a_result_from_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(snap_valid))
    else $error("Result raised without a pending snapshot.");

  a_snapshot_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid && !snap_ready) |=> (snap_valid && $stable(snap)))
    else $error("Snapshot changed while the result stage was full.");

  a_pole_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && result.pole_code != spb_pkg::POLE_NONE) |->
      (result.lon_low == '0 && result.lon_high == spb_pkg::Lon360 &&
       (result.lat_high == spb_pkg::Lat90 || result.lat_low == -spb_pkg::Lat90)))
    else $error("Pole result without the full longitude span.");
`endif

endmodule

`default_nettype wire
